[sv/mi3r_pkg.sv]
package mi3r_pkg;

  localparam int unsigned COEF_W      = 24;
  localparam int unsigned COF_W       = 2 * COEF_W;
  localparam int unsigned DET_W       = 3 * COEF_W + 2;
  localparam int unsigned MAG_W       = DET_W;
  localparam int unsigned THR_W       = 40;
  localparam int unsigned NUM_W       = 32;
  localparam int unsigned LANES       = 9;
  localparam int unsigned FRAC_BITS_D = 20;
  localparam longint unsigned DENOM_D = 64'd1000000;
  localparam logic [THR_W-1:0] THR_RESET = 40'd1152922;

endpackage

[sv/mi3r_lane.sv]
// One lane: restoring divider pipeline, one quotient bit per stage.
// Produces round(|cof| * DENOM * 2^FRAC / |det|), saturated and signed.
module mi3r_lane #(
  parameter int unsigned FRAC_BITS      = mi3r_pkg::FRAC_BITS_D,
  parameter longint unsigned RATIONAL_DENOM = mi3r_pkg::DENOM_D
) (
  input  logic                           clk,
  input  logic                           adv,
  input  logic [mi3r_pkg::COF_W-1:0]     cof_mag,
  input  logic                           neg,
  input  logic [mi3r_pkg::MAG_W-1:0]     det_mag,
  output logic signed [mi3r_pkg::NUM_W-1:0] num
);
  localparam int unsigned DW = mi3r_pkg::MAG_W + 1;   // 2*|det|
  localparam int unsigned QW = mi3r_pkg::NUM_W + 1;   // enough to detect saturation
  localparam int unsigned ST = QW;
  localparam int unsigned PW = mi3r_pkg::COF_W + 31 + FRAC_BITS + 1 + 1;

  // Stage 0: form numerator 2*|cof|*DENOM*2^FRAC + |det|
  logic [PW-1:0] n0_r;
  logic [DW-1:0] d0_r;
  logic          s0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      n0_r <= ((PW'(cof_mag) * PW'(RATIONAL_DENOM)) << (FRAC_BITS + 1)) + PW'(det_mag);
      d0_r <= {det_mag, 1'b0};
      s0_r <= neg;
    end
  end

  // Overflow check: quotient >= 2^QW means saturate
  logic ovf0;
  assign ovf0 = (n0_r >> QW) >= PW'(d0_r);

  // Division stages, MSB first
  logic [PW-1:0] rem_r [ST+1];
  logic [QW-1:0] q_r   [ST+1];
  logic [DW-1:0] d_r   [ST+1];
  logic          sg_r  [ST+1];
  logic          ov_r  [ST+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= n0_r;
      q_r[0]   <= '0;
      d_r[0]   <= d0_r;
      sg_r[0]  <= s0_r;
      ov_r[0]  <= ovf0;
    end
  end

  for (genvar k = 0; k < ST; k++) begin : g_div
    localparam int unsigned SH = QW - 1 - k;
    logic [PW-1:0] dsh;
    logic          ge;
    assign dsh = PW'(d_r[k]) << SH;
    // Compare on the shifted-down remainder; the shifted divisor may not fit
    assign ge  = (rem_r[k] >> SH) >= PW'(d_r[k]);
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= ge ? rem_r[k] - dsh : rem_r[k];
        q_r[k+1]   <= q_r[k] | (QW'(ge) << SH);
        d_r[k+1]   <= d_r[k];
        sg_r[k+1]  <= sg_r[k];
        ov_r[k+1]  <= ov_r[k];
      end
    end
  end

  // Sign and clamp
  logic [QW-1:0] q;
  assign q = q_r[ST];
  always_comb begin
    if (q == '0) begin
      num = '0;
    end else if (sg_r[ST]) begin
      if (ov_r[ST] || q > QW'(33'h080000000)) num = 32'sh80000000;
      else num = mi3r_pkg::NUM_W'(-q);
    end else begin
      if (ov_r[ST] || q > QW'(33'h07fffffff)) num = 32'sh7fffffff;
      else num = mi3r_pkg::NUM_W'(q);
    end
  end
endmodule

[sv/mi3r_front.sv]
// Cofactor and determinant front end, two registered stages.
module mi3r_front (
  input  logic clk,
  input  logic adv,
  input  logic signed [mi3r_pkg::COEF_W-1:0] co [9],
  output logic signed [mi3r_pkg::COF_W:0]    cof [9],
  output logic signed [mi3r_pkg::DET_W-1:0]  det
);
  localparam int unsigned CW = mi3r_pkg::COF_W + 1;
  localparam int unsigned PW = mi3r_pkg::COF_W;
  logic signed [PW-1:0] p_r [18];
  logic signed [mi3r_pkg::COEF_W-1:0] a_r, b_r, c_r;
  logic signed [CW-1:0] cof_c [9];
  logic signed [mi3r_pkg::DET_W-1:0] t_r [3];

  // Stage 1: two-coefficient products
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0]  <= co[4]*co[8]; p_r[1]  <= co[5]*co[7];
      p_r[2]  <= co[2]*co[7]; p_r[3]  <= co[1]*co[8];
      p_r[4]  <= co[1]*co[5]; p_r[5]  <= co[2]*co[4];
      p_r[6]  <= co[5]*co[6]; p_r[7]  <= co[3]*co[8];
      p_r[8]  <= co[0]*co[8]; p_r[9]  <= co[2]*co[6];
      p_r[10] <= co[2]*co[3]; p_r[11] <= co[0]*co[5];
      p_r[12] <= co[3]*co[7]; p_r[13] <= co[4]*co[6];
      p_r[14] <= co[1]*co[6]; p_r[15] <= co[0]*co[7];
      p_r[16] <= co[0]*co[4]; p_r[17] <= co[1]*co[3];
      a_r <= co[0]; b_r <= co[1]; c_r <= co[2];
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_cof
    assign cof_c[k] = CW'(p_r[2*k]) - CW'(p_r[2*k+1]);
  end

  // Stage 2: cofactors and determinant terms
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) cof[k] <= cof_c[k];
      t_r[0] <= mi3r_pkg::DET_W'(a_r * cof_c[0]);
      t_r[1] <= mi3r_pkg::DET_W'(b_r * cof_c[3]);
      t_r[2] <= mi3r_pkg::DET_W'(c_r * cof_c[6]);
    end
  end
  assign det = t_r[0] + t_r[1] + t_r[2];
endmodule

[sv/matrix_inverse_3x3_rational.sv]
// 3x3 matrix inverse with rational outputs. A fully pipelined datapath takes
// one matrix every cycle. The pipeline runs through the cofactor and
// determinant stages, the singularity check, numerator forming, the overflow
// check, 33 restoring-division stages in each of nine parallel lanes, and the
// output register. The whole pipeline halts while out_stall holds a word.
module matrix_inverse_3x3_rational #(
  parameter int unsigned FRAC_BITS = mi3r_pkg::FRAC_BITS_D,
  parameter longint unsigned RATIONAL_DENOM = mi3r_pkg::DENOM_D
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [23:0] in_coef_a, in_coef_b, in_coef_c,
  input  logic signed [23:0] in_coef_d, in_coef_e, in_coef_f,
  input  logic signed [23:0] in_coef_g, in_coef_h, in_coef_i,
  output logic out_valid,
  input  logic out_stall,
  output logic out_invertible,
  output logic signed [31:0] out_num_00, out_num_01, out_num_02,
  output logic signed [31:0] out_num_10, out_num_11, out_num_12,
  output logic signed [31:0] out_num_20, out_num_21, out_num_22,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [39:0] cfg_min_abs_det
);
  localparam int unsigned DEPTH = 2 + 1 + 1 + 1 + (mi3r_pkg::NUM_W + 1) + 1;
  localparam int unsigned MW = mi3r_pkg::MAG_W;
  localparam int unsigned CW = mi3r_pkg::COF_W;

  logic adv;
  logic [mi3r_pkg::THR_W-1:0] thr_r;
  logic [DEPTH-1:0] vld_r;
  logic signed [23:0] co [9];
  logic signed [CW:0] cof [9];
  logic signed [mi3r_pkg::DET_W-1:0] det;
  logic [CW-1:0] cm_r [9];
  logic          ng_r [9];
  logic [MW-1:0] dm_r;
  logic          inv_r [DEPTH-3];
  logic signed [31:0] lane_num [9];
  logic [MW-1:0] dmag;
  logic signed [31:0] num_r [9];
  logic               out_inv_r;

  // Stall everything while the output word waits
  assign adv       = !(vld_r[DEPTH-1] && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= mi3r_pkg::THR_RESET;
    else if (cfg_valid) thr_r <= cfg_min_abs_det;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[DEPTH-2:0], in_valid};
  end

  assign co = '{in_coef_a, in_coef_b, in_coef_c, in_coef_d, in_coef_e,
                in_coef_f, in_coef_g, in_coef_h, in_coef_i};

  mi3r_front u_front (.clk(clk), .adv(adv), .co(co), .cof(cof), .det(det));

  // Singularity check and sign split
  assign dmag = det[mi3r_pkg::DET_W-1] ? MW'(-det) : MW'(det);
  always_ff @(posedge clk) begin
    if (adv) begin
      dm_r     <= dmag;
      inv_r[0] <= (dmag != '0) && (dmag >= MW'(thr_r));
      for (int k = 0; k < 9; k++) begin
        cm_r[k] <= cof[k][CW] ? CW'(-cof[k]) : CW'(cof[k]);
        ng_r[k] <= cof[k][CW] ^ det[mi3r_pkg::DET_W-1];
      end
    end
  end

  // Carry the flag alongside the lanes
  for (genvar s = 1; s < DEPTH - 3; s++) begin : g_flag
    always_ff @(posedge clk) if (adv) inv_r[s] <= inv_r[s-1];
  end

  // Nine divider lanes; a singular matrix divides by one and is zeroed later
  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3r_lane #(.FRAC_BITS(FRAC_BITS), .RATIONAL_DENOM(RATIONAL_DENOM)) u_lane (
      .clk(clk), .adv(adv), .cof_mag(cm_r[k]), .neg(ng_r[k]),
      .det_mag(inv_r[0] ? dm_r : MW'(1)), .num(lane_num[k]));
  end

  // Merge lanes into the output word
  always_ff @(posedge clk) begin
    if (adv) begin
      out_inv_r <= inv_r[DEPTH-4];
      for (int k = 0; k < 9; k++) num_r[k] <= inv_r[DEPTH-4] ? lane_num[k] : '0;
    end
  end

  assign out_invertible = out_inv_r;
  assign out_num_00 = num_r[0]; assign out_num_01 = num_r[1]; assign out_num_02 = num_r[2];
  assign out_num_10 = num_r[3]; assign out_num_11 = num_r[4]; assign out_num_12 = num_r[5];
  assign out_num_20 = num_r[6]; assign out_num_21 = num_r[7]; assign out_num_22 = num_r[8];
endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  typedef logic signed [23:0] coef_t;

  typedef struct packed {
    logic             invertible;
    logic [8:0][31:0] num;
  } inverse_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coef_t in_coef [9];
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_invertible;
  logic signed [31:0] out_num [9];
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [39:0] cfg_min_abs_det = '0;

  // threshold mirror, queue of pending inverses, error tally
  logic [39:0] det_floor;
  inverse_t pending_inv [$];
  int errors = 0;
  bit hold_rx = 1'b0;
  bit no_gaps = 1'b0;
  int rx_hold = 0;

  initial begin
    for (int k = 0; k < 9; k++) in_coef[k] = '0;
  end

  matrix_inverse_3x3_rational uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coef_a(in_coef[0]), .in_coef_b(in_coef[1]), .in_coef_c(in_coef[2]),
    .in_coef_d(in_coef[3]), .in_coef_e(in_coef[4]), .in_coef_f(in_coef[5]),
    .in_coef_g(in_coef[6]), .in_coef_h(in_coef[7]), .in_coef_i(in_coef[8]),
    .out_valid(out_valid), .out_stall(out_stall), .out_invertible(out_invertible),
    .out_num_00(out_num[0]), .out_num_01(out_num[1]), .out_num_02(out_num[2]),
    .out_num_10(out_num[3]), .out_num_11(out_num[4]), .out_num_12(out_num[5]),
    .out_num_20(out_num[6]), .out_num_21(out_num[7]), .out_num_22(out_num[8]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_min_abs_det(cfg_min_abs_det)
  );

  always #6 clk = ~clk;

  // exact inverse as numerators over one million times 2^20, rounded half away from zero
  function automatic inverse_t invert_matrix(coef_t m [9], logic [39:0] floor_v);
    logic signed [127:0] x [9];
    logic signed [127:0] cof [9];
    logic signed [127:0] det;
    logic [127:0] dmag, mag, num, q;
    bit dneg, neg;
    inverse_t r;
    for (int k = 0; k < 9; k++) x[k] = 128'(m[k]);
    cof[0] = x[4] * x[8] - x[5] * x[7];
    cof[1] = x[2] * x[7] - x[1] * x[8];
    cof[2] = x[1] * x[5] - x[2] * x[4];
    cof[3] = x[5] * x[6] - x[3] * x[8];
    cof[4] = x[0] * x[8] - x[2] * x[6];
    cof[5] = x[2] * x[3] - x[0] * x[5];
    cof[6] = x[3] * x[7] - x[4] * x[6];
    cof[7] = x[1] * x[6] - x[0] * x[7];
    cof[8] = x[0] * x[4] - x[1] * x[3];
    det = x[0] * cof[0] + x[1] * cof[3] + x[2] * cof[6];
    dneg = det < 0;
    dmag = dneg ? -det : det;
    r = '0;
    if (dmag == 0 || dmag < {88'd0, floor_v}) return r;
    r.invertible = 1'b1;
    for (int k = 0; k < 9; k++) begin
      mag = (cof[k] < 0) ? -cof[k] : cof[k];
      num = ((mag * 128'd1000000) << 21) + dmag;
      q = num / (dmag << 1);
      neg = ((cof[k] < 0) != dneg) && (q != 0);
      if (neg) r.num[k] = (q > 128'h8000_0000) ? 32'h8000_0000 : 32'(-q);
      else r.num[k] = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
    errors++;
  endtask

  // record the expected inverse for each accepted word
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_inv.insert(pending_inv.size(), invert_matrix(in_coef, det_floor));
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    inverse_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_inv.size() == 0) begin
        report("unexpected word", 32'd0, 32'd1);
      end else begin
        want = pending_inv.pop_front();
        if (out_invertible !== want.invertible)
          report("invertible", 32'(want.invertible), 32'(out_invertible));
        for (int k = 0; k < 9; k++)
          if (out_num[k] !== want.num[k]) report($sformatf("num_%0d%0d", k / 3, k % 3),
                                                 want.num[k], out_num[k]);
      end
    end
  end

  // receiver stall: mostly ready, short and occasional long holds
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_rx) out_stall <= 1'b1;
    else if (no_gaps) out_stall <= 1'b0;
    else if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end
    else if (r < 70) out_stall <= 1'b0;
    else if (r < 98) out_stall <= 1'b1;
    else begin
      rx_hold = $urandom_range(10, 40);
      out_stall <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_matrix(coef_t m [9]);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    for (int k = 0; k < 9; k++) in_coef[k] = m[k];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drain the pipeline, then write the threshold
  task automatic write_floor(logic [39:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_inv.size() == 0);
    repeat (45) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_min_abs_det = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    det_floor = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic coef_t rand_coef(int kind);
    case (kind)
      0: return coef_t'($urandom);
      1: return coef_t'($signed($urandom_range(0, 4095)) - 2048);
      2: return ($urandom_range(0, 1) == 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return coef_t'($signed($urandom_range(0, 3 << 20)) - (3 << 19));
    endcase
  endfunction

  task automatic random_matrix(output coef_t m [9]);
    int kind, shape;
    kind = $urandom_range(0, 3);
    shape = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) m[k] = rand_coef($urandom_range(0, 9) == 0 ? 2 : kind);
    // make some rank deficient, some near identity
    if (shape == 0) for (int k = 0; k < 3; k++) m[3 + k] = m[k];
    else if (shape == 1) for (int k = 0; k < 3; k++) m[6 + k] = -m[k];
    else if (shape == 2) begin
      for (int k = 0; k < 9; k++) m[k] = coef_t'($signed($urandom_range(0, 63)) - 32);
      m[0] += 24'sd1 <<< 20; m[4] += 24'sd1 <<< 20; m[8] += 24'sd1 <<< 20;
    end
  endtask

  task automatic set_diag(output coef_t m [9], input coef_t p, coef_t q, coef_t r);
    for (int k = 0; k < 9; k++) m[k] = '0;
    m[0] = p; m[4] = q; m[8] = r;
  endtask

  task automatic test_directed();
    coef_t m [9];
    set_diag(m, 24'sd1 <<< 20, 24'sd1 <<< 20, 24'sd1 <<< 20); send_matrix(m);
    set_diag(m, -(24'sd1 <<< 20), 24'sd2 <<< 20, 24'sd3 <<< 20); send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = '0; send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = 24'sh7FFFFF; send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = 24'sh800000; send_matrix(m);
    // threshold boundary: det equal to and just under the reset value
    set_diag(m, 24'sd1, 24'sd1, 24'sd1152922); send_matrix(m);
    set_diag(m, 24'sd1, 24'sd1, 24'sd1152921); send_matrix(m);
    set_diag(m, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF); send_matrix(m);
    set_diag(m, 24'sh800000, 24'sh800000, 24'sh800000); send_matrix(m);
    m = '{24'sh7FFFFF, 24'sh800000, 24'sd0, 24'sd0, 24'sh7FFFFF, 24'sh800000,
          24'sh800000, 24'sd0, 24'sh7FFFFF};
    send_matrix(m);
    // tiny determinant with no threshold: quotients saturate both ways
    write_floor(40'd0);
    set_diag(m, 24'sd1, 24'sd1, 24'sd1); send_matrix(m);
    set_diag(m, 24'sd1, -24'sd1, 24'sd1); m[1] = 24'sd5; send_matrix(m);
    set_diag(m, 24'sd3, 24'sd1 <<< 20, 24'sd1 <<< 20); send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = 24'sd7; send_matrix(m);
    write_floor(40'hFF_FFFF_FFFF);
    set_diag(m, 24'sd1 <<< 20, 24'sd1 <<< 20, 24'sd1 <<< 20); send_matrix(m);
    set_diag(m, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF); send_matrix(m);
  endtask

  task automatic test_random(int count);
    coef_t m [9];
    for (int n = 0; n < count; n++) begin
      no_gaps = (n % 200) >= 150;
      random_matrix(m);
      send_matrix(m);
    end
    no_gaps = 1'b0;
  endtask

  // hold the receiver off while the sender keeps offering words
  task automatic test_backpressure();
    coef_t m [9];
    fork
      begin
        hold_rx = 1'b1;
        repeat (300) @(negedge clk);
        hold_rx = 1'b0;
      end
      begin
        no_gaps = 1'b1;
        for (int n = 0; n < 100; n++) begin
          random_matrix(m);
          send_matrix(m);
        end
        no_gaps = 1'b0;
      end
    join
  endtask

  initial begin
    #20_000_000;
    $display("matrix_inverse_3x3_rational regression: fail");
    $finish;
  end

  initial begin
    det_floor = mi3r_pkg::THR_RESET;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    write_floor(mi3r_pkg::THR_RESET);
    test_random(300);
    write_floor(40'd0);
    test_random(200);
    write_floor(40'($urandom) | (40'($urandom_range(0, 255)) << 32));
    test_random(200);
    test_backpressure();
    write_floor(40'hFF_FFFF_FFFF);
    test_random(200);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_inv.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("matrix_inverse_3x3_rational regression: pass");
    else $display("matrix_inverse_3x3_rational regression: fail");
    $finish;
  end

endmodule
